>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, constants and link structs of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

   // exponent bits scanned, most significant first
   localparam int EXP_BITS = 32;
   localparam int CNT_W    = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

   // payload widths
   localparam int BASE_W = 31;
   localparam int EXPN_W = 32;
   localparam int RES_W  = 30;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // prime modulus and barrett reciprocal floor(2^62 / p)
   localparam logic [RES_W-1:0]   MOD_P      = 30'd1000000007;
   localparam logic [MUL_B_W-1:0] BARRETT_MU = 33'd4611685986;

   // request to and reply from the modular multiply unit
   typedef struct packed {
      logic              start;
      logic [BASE_W-1:0] op_a;
      logic [BASE_W-1:0] op_b;
   } mm_req_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] res;
   } mm_rsp_type;

endpackage

>>> sv/mexp_req_if.sv
// ----------------------------------------------------------------------------
// mexp_req_if
// request channel: base and exponent word with valid / ready
// ----------------------------------------------------------------------------
interface mexp_req_if;
   import mexp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base;
   logic [EXPN_W-1:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

>>> sv/mexp_rsp_if.sv
// ----------------------------------------------------------------------------
// mexp_rsp_if
// response channel: result word with valid / ready
// ----------------------------------------------------------------------------
interface mexp_rsp_if;
   import mexp_pkg::*;

   logic             valid;
   logic             ready;
   logic [RES_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

>>> sv/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// modular multiply a * b mod p on one shared multiplier, barrett reduction
// ----------------------------------------------------------------------------
module mexp_modmul (
   input  logic                 clock,
   input  logic                 reset,
   input  mexp_pkg::mm_req_type mm_req,
   output mexp_pkg::mm_rsp_type mm_rsp
);
   import mexp_pkg::*;

   typedef enum logic [2:0] {
      MM_IDLE,
      MM_EST,
      MM_QP,
      MM_SUB,
      MM_CORR
   } mm_state_type;

   mm_state_type        state_ff, state_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [MUL_A_W-1:0]  x_lo_ff, x_lo_in;
   logic [MUL_A_W-1:0]  rem_ff, rem_in;
   logic                done_ff, done_in;
   logic [RES_W-1:0]    res_ff, res_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;

   // operand select for the one multiplier
   always_comb begin
      unique case (state_ff)
         MM_IDLE: begin
            mul_a = {1'b0, mm_req.op_a};
            mul_b = {2'b00, mm_req.op_b};
         end
         MM_EST: begin
            // top 32 bits of the product times the reciprocal
            mul_a = prod_ff[60:29];
            mul_b = BARRETT_MU;
         end
         MM_QP: begin
            // quotient estimate times the modulus
            mul_a = prod_ff[PROD_W-1:33];
            mul_b = {3'b000, MOD_P};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      x_lo_in  = x_lo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               prod_in  = mul_p;
               state_in = MM_EST;
            end
         end
         MM_EST: begin
            x_lo_in  = prod_ff[MUL_A_W-1:0];
            prod_in  = mul_p;
            state_in = MM_QP;
         end
         MM_QP: begin
            prod_in  = mul_p;
            state_in = MM_SUB;
         end
         MM_SUB: begin
            // true remainder is below 3p, so low 32 bits suffice
            rem_in   = x_lo_ff - prod_ff[MUL_A_W-1:0];
            state_in = MM_CORR;
         end
         MM_CORR: begin
            if (rem_ff >= MUL_A_W'(MOD_P)) begin
               rem_in = rem_ff - MUL_A_W'(MOD_P);
            end else begin
               res_in   = rem_ff[RES_W-1:0];
               done_in  = 1'b1;
               state_in = MM_IDLE;
            end
         end
         default: state_in = MM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      x_lo_ff <= x_lo_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.res  = res_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> state_ff == MM_IDLE)
      else $error("modmul started while busy");

   a_done_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> res_ff < MOD_P)
      else $error("modmul result not reduced");

   a_corr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MM_CORR && $past(state_ff) == MM_CORR
       && $past(state_ff, 2) == MM_CORR) |-> rem_ff < MUL_A_W'(MOD_P))
      else $error("more than two correction steps");

endmodule

>>> sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod 1000000007 by square-and-multiply on a shared unit
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one word of base (31 bits) and exponent (32 bits); it is
//   taken when valid and ready are both high. ready is high only while the
//   block is idle, so one word is in work at a time.
//   rsp_chan returns one result word (30 bits, below the prime) per request.
//   the exponent is scanned from its top bit down: each bit costs a modular
//   square, and each set bit a further modular multiply by the base.
//   every modular multiply runs on the one 32 x 33 multiplier in three
//   passes (product, barrett estimate, quotient times modulus), then a
//   subtract and up to two correction steps.
//   an exponent of zero gives 1, also for a zero base.
//   reset is synchronous, active high; it clears the sequencer and drops
//   rsp valid. a finished result sits in the output register until taken;
//   a new request is taken meanwhile, and if that one finishes before the
//   receiver takes the old word the block holds off until the slot frees.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input logic        clock,
   input logic        reset,
   mexp_req_if.sink   req_chan,
   mexp_rsp_if.source rsp_chan
);
   import mexp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [EXP_BITS-1:0]   exp_ff, exp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RES_W-1:0]      acc_ff, acc_in;
   logic                  phase_ff, phase_in;   // high: multiply by base
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]      rsp_result_ff, rsp_result_in;

   mm_req_type            mm_req;
   mm_rsp_type            mm_rsp;

   logic                  req_take;
   logic                  rsp_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   // output slot is free when empty or being drained this cycle
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // square uses acc twice, multiply uses acc and the raw base
   assign mm_req.start = (state_ff == S_ISSUE);
   assign mm_req.op_a  = {1'b0, acc_ff};
   assign mm_req.op_b  = phase_ff ? base_ff : {1'b0, acc_ff};

   mexp_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;

      // word taken by the receiver
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               base_in  = req_chan.base;
               // narrow scan drops high bits, wide scan pads with zero
               exp_in   = EXP_BITS'(req_chan.exponent);
               cnt_in   = CNT_W'(EXP_BITS - 1);
               acc_in   = RES_W'(1);
               phase_in = 1'b0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.res;
               if (!phase_ff && exp_ff[EXP_BITS-1]) begin
                  // set bit: follow the square with a multiply by base
                  phase_in = 1'b1;
                  state_in = S_ISSUE;
               end else begin
                  phase_in = 1'b0;
                  exp_in   = exp_ff << 1;
                  if (cnt_ff == '0) begin
                     state_in = S_OUT;
                  end else begin
                     cnt_in   = cnt_ff - CNT_W'(1);
                     state_in = S_ISSUE;
                  end
               end
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("request taken while a word is in work");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff < MOD_P)
      else $error("result not below the modulus");

   a_issue_from_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> ($past(state_ff) == S_IDLE
                                 || $past(state_ff) == S_WAIT))
      else $error("multiply issued out of sequence");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the modular exponentiation block
// ----------------------------------------------------------------------------
// request words go in through req_chan and every result word is matched, in
// order, against a prediction of base ^ exponent mod 1000000007. a short
// table of corner words comes first, then random words. both handshake
// sides idle at random, except for one long steady stretch.
// ----------------------------------------------------------------------------
module testbench;
   import mexp_pkg::*;

   // one word in flight: operands kept for the mismatch report
   typedef struct {
      logic [BASE_W-1:0] base;
      logic [EXPN_W-1:0] exponent;
      logic [RES_W-1:0]  result;
   } power_job_type;

   // corner table row: result typed in only where it is obvious
   typedef struct {
      logic [BASE_W-1:0] base;
      logic [EXPN_W-1:0] exponent;
      bit                typed;
      logic [RES_W-1:0]  result;
   } corner_row_type;

   localparam int RANDOM_WORDS  = 1900;
   localparam int DRAIN_CYCLES  = 600;       // longer than the worst word latency
   localparam int STEADY_FIRST  = 700;       // random words sent with no idling
   localparam int STEADY_LAST   = 1000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [BASE_W-1:0] BASE_MAX = '1;
   localparam logic [EXPN_W-1:0] EXPN_MAX = '1;
   localparam logic [BASE_W-1:0] BASE_P   = BASE_W'(MOD_P);

   localparam int CORNER_ROWS = 20;

   logic clock = 1'b0;
   logic reset;

   mexp_req_if req_chan ();
   mexp_rsp_if rsp_chan ();

   modular_exponentiation u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // words queued by the sender but not yet taken, and words taken whose
   // result has not yet come back
   power_job_type queued_jobs[$];
   power_job_type pending_jobs[$];
   int            mismatches = 0;
   bit            steady     = 1'b0;    // no idling on either side while set

   corner_row_type corner_rows [CORNER_ROWS] = '{
      // zero exponent gives 1, zero base included
      '{31'd0,            32'd0,          1'b1, 30'd1},
      '{BASE_MAX,         32'd0,          1'b1, 30'd1},
      // zero base with a nonzero exponent gives 0; then base one and base two
      '{31'd0,            32'd1,          1'b1, 30'd0},
      '{31'd0,            EXPN_MAX,       1'b1, 30'd0},
      '{31'd1,            EXPN_MAX,       1'b1, 30'd1},
      '{31'd2,            32'd1,          1'b1, 30'd2},
      // base at or above the prime is used unreduced
      '{BASE_MAX,         32'd1,          1'b1, 30'd147483633},
      '{BASE_P,           32'd1,          1'b1, 30'd0},
      '{BASE_P + 31'd1,   EXPN_MAX,       1'b1, 30'd1},
      // largest result, and minus one squared
      '{BASE_P - 31'd1,   32'd1,          1'b1, MOD_P - 30'd1},
      '{BASE_P - 31'd1,   32'd2,          1'b1, 30'd1},
      // the rest go through the predictor
      '{BASE_P - 31'd1,   EXPN_MAX,       1'b0, 30'd0},
      '{31'd2,            EXPN_MAX,       1'b0, 30'd0},
      '{BASE_MAX,         EXPN_MAX,       1'b0, 30'd0},
      '{31'd3,            32'd1000000006, 1'b0, 30'd0},
      '{31'd7,            32'd10,         1'b0, 30'd0},
      '{31'd2,            32'd30,         1'b0, 30'd0},
      '{31'd12345,        32'h8000_0000,  1'b0, 30'd0},
      '{31'h5555_5555,    32'haaaa_aaaa,  1'b0, 30'd0},
      '{31'h2aaa_aaaa,    32'h5555_5555,  1'b0, 30'd0}
   };

   // square-and-multiply over the scanned exponent bits, top bit first;
   // bits the scan does not reach are ignored, bits beyond the field read 0
   function automatic logic [RES_W-1:0] power_mod_prime(
      input logic [BASE_W-1:0] base,
      input logic [EXPN_W-1:0] exponent
   );
      longint unsigned running;
      longint unsigned modulus;
      running = 1;
      modulus = 64'(MOD_P);
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
         running = (running * running) % modulus;
         if ((i < EXPN_W) && exponent[i % EXPN_W])
            running = (running * 64'(base)) % modulus;
      end
      return RES_W'(running);
   endfunction

   // base mix: zero, one, around the prime, near the top, small, anything
   function automatic logic [BASE_W-1:0] pick_base();
      case ($urandom_range(9))
         0: return '0;
         1: return BASE_W'(1);
         2: return BASE_P + BASE_W'($urandom_range(2)) - BASE_W'(1);
         3: return BASE_MAX - BASE_W'($urandom_range(3));
         4: return BASE_W'($urandom_range(1000));
         default: return BASE_W'($urandom);
      endcase
   endfunction

   // exponent mix: zero, all ones, one bit, small, anything
   function automatic logic [EXPN_W-1:0] pick_exponent();
      case ($urandom_range(9))
         0: return '0;
         1: return EXPN_MAX;
         2: return EXPN_W'(1) << $urandom_range(EXPN_W - 1);
         3: return EXPN_W'($urandom_range(255));
         default: return EXPN_W'($urandom);
      endcase
   endfunction

   // hold valid high with the word until the block takes it
   task automatic offer_word(
      input logic [BASE_W-1:0] base,
      input logic [EXPN_W-1:0] exponent,
      input logic [RES_W-1:0]  result
   );
      power_job_type job;
      job = '{base, exponent, result};
      queued_jobs = {queued_jobs, job};
      req_chan.valid    <= 1'b1;
      req_chan.base     <= base;
      req_chan.exponent <= exponent;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // random sender gap, skipped in the steady stretch
   task automatic sender_gap();
      if (!steady && $urandom_range(99) < 17) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending until every result is back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (queued_jobs.size() != 0 || pending_jobs.size() != 0);
   endtask

   // receiver: ready drops at random about 17 percent of the time, never in the steady stretch
   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 17);
   end

   // word taken: move its expectation to the pending queue;
   // result word taken: compare with the oldest pending expectation
   always @(posedge clock) begin
      power_job_type job;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            job = queued_jobs.pop_front();
            pending_jobs = {pending_jobs, job};
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_jobs.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result %0d with no word outstanding",
                           $realtime, rsp_chan.result);
            end else begin
               job = pending_jobs.pop_front();
               if (rsp_chan.result !== job.result) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: base %0d exponent %0d: result %0d, expected %0d",
                              $realtime, job.base, job.exponent, rsp_chan.result,
                              job.result);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [BASE_W-1:0] base;
      logic [EXPN_W-1:0] exponent;

      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.base     = '0;
      req_chan.exponent = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corner table
      foreach (corner_rows[i]) begin
         sender_gap();
         offer_word(corner_rows[i].base, corner_rows[i].exponent,
                    corner_rows[i].typed ? corner_rows[i].result
                                         : power_mod_prime(corner_rows[i].base,
                                                           corner_rows[i].exponent));
      end
      wait_for_results();

      // random words, with a steady stretch and a full drain halfway
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
         if (n == RANDOM_WORDS / 2)
            wait_for_results();
         else
            sender_gap();
         base     = pick_base();
         exponent = pick_exponent();
         offer_word(base, exponent, power_mod_prime(base, exponent));
      end
      steady = 1'b0;

      // let every result come back, then watch a while for stray words
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> modular_exponentiation.f
sv/mexp_pkg.sv
sv/mexp_req_if.sv
sv/mexp_rsp_if.sv
sv/mexp_modmul.sv
sv/modular_exponentiation.sv
bench/testbench.sv
